>>> rtl/rdi_pkg.sv
// shared types, constants and face tables for the ray / dodecahedron clipper
// no dependencies
package rdi_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_FACES     = 12;
    localparam int ACC_W         = 67;
    localparam int MUL_A_W       = 37;
    localparam int MUL_B_W       = 30;
    localparam int GEO_SHIFT     = 28;

    localparam logic [3:0] NO_FACE   = 4'd12;
    localparam logic [3:0] LAST_FACE = 4'd11;

    localparam logic [1:0] CFG_CENTER_X = 2'd0;
    localparam logic [1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [1:0] CFG_CENTER_Z = 2'd2;
    localparam logic [1:0] CFG_RADIUS   = 2'd3;

    localparam logic signed [31:0] T_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] T_MAX = 32'sh7fff_ffff;

    // Q2.28 geometry constants
    localparam logic signed [MUL_B_W-1:0] C_ONE = 30'sd268435456;
    localparam logic signed [MUL_B_W-1:0] C_PHI = 30'sd434337692;
    localparam logic signed [MUL_B_W-1:0] C_IPH = 30'sd165902236;
    localparam logic signed [MUL_B_W-1:0] C_ZRO = 30'sd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHK,
        S_DWAIT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        D_IDLE,
        D_CHK,
        D_RUN,
        D_FIN
    } t_div_state;

    // face normal component, not normalized
    function automatic logic signed [MUL_B_W-1:0] face_norm(input logic [3:0] face,
                                                            input logic [1:0] axis);
        logic signed [MUL_B_W-1:0] x, y, z;
        begin
            x = C_ZRO; y = C_ZRO; z = C_ZRO;
            case (face)
                4'd0:  begin x =  C_IPH; z =  C_ONE; end
                4'd1:  begin y =  C_ONE; z =  C_IPH; end
                4'd2:  begin x = -C_IPH; z =  C_ONE; end
                4'd3:  begin y = -C_ONE; z =  C_IPH; end
                4'd4:  begin x =  C_IPH; z = -C_ONE; end
                4'd5:  begin y = -C_ONE; z = -C_IPH; end
                4'd6:  begin x = -C_IPH; z = -C_ONE; end
                4'd7:  begin y =  C_ONE; z = -C_IPH; end
                4'd8:  begin x =  C_ONE; y = -C_IPH; end
                4'd9:  begin x =  C_ONE; y =  C_IPH; end
                4'd10: begin x = -C_ONE; y =  C_IPH; end
                4'd11: begin x = -C_ONE; y = -C_IPH; end
                default: begin x = C_ZRO; end
            endcase
            case (axis)
                2'd0:    face_norm = x;
                2'd1:    face_norm = y;
                default: face_norm = z;
            endcase
        end
    endfunction

    // first vertex of each face at unit scale
    function automatic logic signed [MUL_B_W-1:0] face_vert(input logic [3:0] face,
                                                            input logic [1:0] axis);
        logic signed [MUL_B_W-1:0] x, y, z;
        begin
            x = C_ZRO; y = C_ZRO; z = C_ZRO;
            case (face)
                4'd0, 4'd1, 4'd2: begin y =  C_IPH; z =  C_PHI; end
                4'd3:             begin y = -C_IPH; z =  C_PHI; end
                4'd4, 4'd5, 4'd6: begin y = -C_IPH; z = -C_PHI; end
                4'd7:  begin x = -C_ONE; y =  C_ONE; z = -C_ONE; end
                4'd8:  begin x =  C_ONE; y = -C_ONE; z =  C_ONE; end
                4'd9:  begin x =  C_PHI; z =  C_IPH; end
                4'd10: begin x = -C_ONE; y =  C_ONE; z =  C_ONE; end
                4'd11: begin x = -C_PHI; z =  C_IPH; end
                default: begin x = C_ZRO; end
            endcase
            case (axis)
                2'd0:    face_vert = x;
                2'd1:    face_vert = y;
                default: face_vert = z;
            endcase
        end
    endfunction

endpackage

>>> rtl/rdi_div.sv
// restoring divider for plane depth, one quotient bit per cycle, saturating
// depends on rdi_pkg
module rdi_div #(
    parameter int FRAC_BITS = rdi_pkg::FRAC_BITS_DEF,
    parameter int ACC_W     = rdi_pkg::ACC_W
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [ACC_W-1:0] i_num,
    input  logic signed [ACC_W-1:0] i_den,
    output logic                    o_done,
    output logic signed [31:0]      o_quot
);
    import rdi_pkg::*;

    localparam int REM_W = ACC_W + 33;

    t_div_state r_state, n_state;
    logic [REM_W-1:0] r_rem, r_dsh;
    logic [31:0]      r_q;
    logic [4:0]       r_cnt;
    logic             r_neg, r_sat;
    logic [ACC_W-1:0] un, ud;

    assign un = i_num[ACC_W-1] ? ACC_W'(-i_num) : ACC_W'(i_num);
    assign ud = i_den[ACC_W-1] ? ACC_W'(-i_den) : ACC_W'(i_den);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            D_IDLE: if (i_start) n_state = D_CHK;
            D_CHK:  n_state = (r_rem >= {r_dsh[REM_W-2:0], 1'b0}) ? D_FIN : D_RUN;
            D_RUN:  if (r_cnt == 5'd0) n_state = D_FIN;
            D_FIN:  n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    r_neg <= i_num[ACC_W-1] ^ i_den[ACC_W-1];
                    r_rem <= REM_W'(un) << FRAC_BITS;
                    r_dsh <= REM_W'(ud) << 31;
                    r_q   <= '0;
                    r_cnt <= 5'd31;
                end
            end
            // quotient of 2^32 or more saturates without running the bit loop
            D_CHK: r_sat <= (r_rem >= {r_dsh[REM_W-2:0], 1'b0});
            D_RUN: begin
                if (r_rem >= r_dsh) begin
                    r_rem <= r_rem - r_dsh;
                    r_q   <= {r_q[30:0], 1'b1};
                end else begin
                    r_q   <= {r_q[30:0], 1'b0};
                end
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 5'd1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_done = (r_state == D_FIN);
        if (r_sat) begin
            o_quot = r_neg ? T_MIN : T_MAX;
        end else if (r_neg) begin
            o_quot = r_q[31] ? T_MIN : -$signed(r_q);
        end else begin
            o_quot = r_q[31] ? T_MAX : $signed(r_q);
        end
    end

endmodule

>>> rtl/ray_dodecahedron_intersect.sv
// ray against dodecahedron face-plane clipper, top level
// depends on rdi_pkg and rdi_div
//
// usage
//  - config channel (i_cfg_valid / o_cfg_ready, always ready) writes center x/y/z
//    and radius by index 0..3; write only while the block is idle
//  - input channel: one ray per transfer when i_valid is high and o_stall is low;
//    o_stall stays high from the accepted ray until its result is registered
//  - output channel: one result per ray when o_valid is high and i_stall is low
//  - each face uses the shared multiplier (vertex scale, numerator and
//    denominator terms for three axes), then the check state, and, unless the
//    plane is parallel, the divider, which skips its bit loop when the depth
//    saturates early
//  - a ray runs all 12 faces in turn, then its result loads the output register
//  - the output register holds a result under stall; the next ray is taken as
//    soon as the result has been loaded, even if it is still waiting
//  - reset clears the sequencer, the output valid and loads the config defaults
//    (center 0, radius 1.0)
module ray_dodecahedron_intersect #(
    parameter int FRAC_BITS = rdi_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    // ray in
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_origin_x,
    input  logic signed [31:0] i_origin_y,
    input  logic signed [31:0] i_origin_z,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    input  logic signed [31:0] i_dir_z,
    // result out
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_hit,
    output logic signed [31:0] o_t_enter,
    output logic signed [31:0] o_t_exit,
    output logic [3:0]         o_face_enter,
    output logic [3:0]         o_face_exit
);
    import rdi_pkg::*;

    t_state r_state, n_state;

    // config registers
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [30:0]        r_radius;

    // captured ray
    logic signed [31:0] r_ox, r_oy, r_oz, r_dx, r_dy, r_dz;

    // sequencer
    logic [3:0] r_face;
    logic [1:0] r_axis, r_phase;

    // shared multiplier and accumulators
    logic signed [ACC_W-1:0]   r_prod, r_num, r_den;
    logic signed [MUL_A_W-1:0] mul_a, diff;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [31:0]        sel_c, sel_o, sel_d;

    // running extremes
    logic signed [31:0] r_t_in, r_t_out;
    logic [3:0]         r_f_in, r_f_out;

    // divider
    logic               div_start, div_done;
    logic signed [31:0] div_quot;

    logic in_xfer, out_xfer, out_load, face_last, mul_last;

    assign in_xfer   = i_valid && !o_stall;
    assign out_xfer  = o_valid && !i_stall;
    assign face_last = (r_face == LAST_FACE);
    assign mul_last  = (r_axis == 2'd2) && (r_phase == 2'd3);

    rdi_div #(
        .FRAC_BITS (FRAC_BITS),
        .ACC_W     (ACC_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_MUL;
            S_MUL:   if (mul_last) n_state = S_CHK;
            S_CHK: begin
                if (r_den != '0) n_state = S_DWAIT;
                else             n_state = face_last ? S_OUT : S_MUL;
            end
            S_DWAIT: if (div_done) n_state = face_last ? S_OUT : S_MUL;
            S_OUT:   if (!o_valid || !i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_stall     = (r_state != S_IDLE);
        o_cfg_ready = 1'b1;
        div_start   = (r_state == S_CHK) && (r_den != '0);
        out_load    = (r_state == S_OUT) && (!o_valid || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
            r_radius <= 31'(1) << FRAC_BITS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CENTER_X: r_cx     <= i_cfg_data;
                CFG_CENTER_Y: r_cy     <= i_cfg_data;
                CFG_CENTER_Z: r_cz     <= i_cfg_data;
                CFG_RADIUS:   r_radius <= i_cfg_data[30:0];
                default:      r_cx     <= r_cx;
            endcase
        end
    end

    // per-axis operand select
    always_comb begin
        case (r_axis)
            2'd0:    begin sel_c = r_cx; sel_o = r_ox; sel_d = r_dx; end
            2'd1:    begin sel_c = r_cy; sel_o = r_oy; sel_d = r_dy; end
            default: begin sel_c = r_cz; sel_o = r_oz; sel_d = r_dz; end
        endcase
        // plane point minus origin; product is radius*vertex, floored by the shift
        diff = MUL_A_W'(sel_c) + r_prod[GEO_SHIFT+MUL_A_W-1:GEO_SHIFT] - MUL_A_W'(sel_o);
        case (r_phase)
            2'd0: begin
                mul_a = $signed({{(MUL_A_W-31){1'b0}}, r_radius});
                mul_b = face_vert(r_face, r_axis);
            end
            2'd1: begin
                mul_a = diff;
                mul_b = face_norm(r_face, r_axis);
            end
            default: begin
                mul_a = MUL_A_W'(sel_d);
                mul_b = face_norm(r_face, r_axis);
            end
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ox    <= i_origin_x;
            r_oy    <= i_origin_y;
            r_oz    <= i_origin_z;
            r_dx    <= i_dir_x;
            r_dy    <= i_dir_y;
            r_dz    <= i_dir_z;
            r_face  <= '0;
            r_axis  <= '0;
            r_phase <= '0;
            r_num   <= '0;
            r_den   <= '0;
            r_t_in  <= T_MIN;
            r_t_out <= T_MAX;
            r_f_in  <= NO_FACE;
            r_f_out <= NO_FACE;
        end

        if (r_state == S_MUL) begin
            if (r_phase != 2'd3) r_prod <= ACC_W'(mul_a * mul_b);
            if (r_phase == 2'd2) r_num  <= r_num + r_prod;
            if (r_phase == 2'd3) begin
                r_den  <= r_den + r_prod;
                r_axis <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
            end
            r_phase <= r_phase + 2'd1;
        end

        // parallel plane skipped, else keep strictly better depth
        if (((r_state == S_CHK) && (r_den == '0)) || ((r_state == S_DWAIT) && div_done)) begin
            if (r_state == S_DWAIT) begin
                if (r_den[ACC_W-1]) begin
                    if (div_quot > r_t_in) begin
                        r_t_in <= div_quot;
                        r_f_in <= r_face;
                    end
                end else if (div_quot < r_t_out) begin
                    r_t_out <= div_quot;
                    r_f_out <= r_face;
                end
            end
            r_face <= r_face + 4'd1;
            r_num  <= '0;
            r_den  <= '0;
        end
    end

    // output register, holds under stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (out_load) begin
            o_valid <= 1'b1;
        end else if (out_xfer) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_hit        <= (r_t_in <= r_t_out);
            o_t_enter    <= r_t_in;
            o_t_exit     <= r_t_out;
            o_face_enter <= r_f_in;
            o_face_exit  <= r_f_out;
        end
    end

endmodule
